// ----- rtl/ascon_pkg.sv -----
// Package: shared types, constants and the permutation round for the Ascon block core
`default_nettype none
package ascon_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned RND_W    = 4;

    localparam logic [WORD_W-1:0] ASCON_IV = 64'h80400c0600000000;
    localparam logic [RND_W-1:0]  RND_FIRST_FULL = 4'd0;
    localparam logic [RND_W-1:0]  RND_FIRST_HALF = 4'd6;
    localparam logic [RND_W-1:0]  RND_LAST       = 4'd11;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_sponge;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_ENC   = 2'd1,
        REQ_DEC   = 2'd2,
        REQ_FIN   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERM,
        ST_FINISH
    } t_ctrl_state;

    typedef struct packed {
        logic             accept;
        logic             round;
        logic [RND_W-1:0] rnd_idx;
        logic             finish;
    } t_dp_cmd;

    typedef struct packed {
        logic pending;
        logic out_free;
    } t_dp_status;

    // constant for round i of 12: high nibble 0xf - i, low nibble i
    function automatic logic [7:0] round_const(input logic [RND_W-1:0] idx);
        return {4'hf - idx, idx};
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_sponge ascon_round(input t_sponge s_in, input logic [7:0] c);
        t_sponge s;
        t_word   t0, t1, t2, t3, t4;
        s = s_in;
        s[2] = s[2] ^ {56'd0, c};
        s[0] = s[0] ^ s[4];
        s[4] = s[4] ^ s[3];
        s[2] = s[2] ^ s[1];
        t0 = ~s[0] & s[1];
        t1 = ~s[1] & s[2];
        t2 = ~s[2] & s[3];
        t3 = ~s[3] & s[4];
        t4 = ~s[4] & s[0];
        s[0] = s[0] ^ t1;
        s[1] = s[1] ^ t2;
        s[2] = s[2] ^ t3;
        s[3] = s[3] ^ t4;
        s[4] = s[4] ^ t0;
        s[1] = s[1] ^ s[0];
        s[0] = s[0] ^ s[4];
        s[3] = s[3] ^ s[2];
        s[2] = ~s[2];
        s[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
        s[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
        s[2] = s[2] ^ rotr(s[2], 1) ^ rotr(s[2], 6);
        s[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
        s[4] = s[4] ^ rotr(s[4], 7) ^ rotr(s[4], 41);
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ascon_ctrl.sv -----
// Controller: request sequencing and round counting for the Ascon block core
`default_nettype none
module ascon_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_req_type,
    input  wire ascon_pkg::t_dp_status i_status,
    output ascon_pkg::t_dp_cmd         o_cmd
);
    import ascon_pkg::*;

    t_ctrl_state      r_state, n_state;
    logic [RND_W-1:0] r_rnd, n_rnd;
    t_req             req;

    assign req = t_req'(i_req_type);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= RND_FIRST_FULL;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_rnd         = r_rnd;
        o_in_ready    = 1'b0;
        o_cmd.accept  = 1'b0;
        o_cmd.round   = 1'b0;
        o_cmd.rnd_idx = r_rnd;
        o_cmd.finish  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (req)
                        REQ_START, REQ_FIN: begin
                            n_rnd   = RND_FIRST_FULL;
                            n_state = ST_PERM;
                        end
                        REQ_ENC, REQ_DEC: begin
                            n_rnd   = RND_FIRST_HALF;
                            n_state = i_status.pending ? ST_FINISH : ST_PERM;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PERM: begin
                o_cmd.round = 1'b1;
                if (r_rnd == RND_LAST) begin
                    n_state = ST_FINISH;
                end else begin
                    n_rnd = r_rnd + 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/ascon_dp.sv -----
// Datapath: sponge state, key registers, round logic and output word register
`default_nettype none
module ascon_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ascon_pkg::t_dp_cmd  i_cmd,
    output ascon_pkg::t_dp_status    o_status,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_index,
    input  wire ascon_pkg::t_word    i_cfg_data,
    input  wire logic [1:0]          i_req_type,
    input  wire ascon_pkg::t_word    i_data_word,
    input  wire ascon_pkg::t_word    i_nonce_high,
    input  wire ascon_pkg::t_word    i_nonce_low,
    input  wire ascon_pkg::t_word    i_expected_tag_high,
    input  wire ascon_pkg::t_word    i_expected_tag_low,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ascon_pkg::t_word         o_out_word,
    output ascon_pkg::t_word         o_tag_high,
    output ascon_pkg::t_word         o_tag_low,
    output logic                     o_tag_match
);
    import ascon_pkg::*;

    t_sponge r_s, n_s;
    logic    r_pending, n_pending;
    t_word   r_key_hi, r_key_lo;
    t_req    r_req;
    t_word   r_data, r_exp_hi, r_exp_lo;
    logic    r_out_valid;
    t_word   r_out_word, r_tag_hi, r_tag_lo;
    logic    r_tag_match;
    t_word   n_out_word, n_tag_hi, n_tag_lo;
    logic    n_tag_match;
    t_sponge round_out;

    assign round_out = ascon_round(r_s, round_const(i_cmd.rnd_idx));

    assign o_status.pending  = r_pending;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_KEY_HIGH) begin
                r_key_hi <= i_cfg_data;
            end else begin
                r_key_lo <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= t_req'(i_req_type);
            r_data   <= i_data_word;
            r_exp_hi <= i_expected_tag_high;
            r_exp_lo <= i_expected_tag_low;
        end
    end

    always_comb begin
        n_s         = r_s;
        n_pending   = r_pending;
        n_out_word  = '0;
        n_tag_hi    = '0;
        n_tag_lo    = '0;
        n_tag_match = 1'b0;
        if (i_cmd.accept) begin
            unique case (t_req'(i_req_type))
                REQ_START: begin
                    n_s[0] = ASCON_IV;
                    n_s[1] = r_key_hi;
                    n_s[2] = r_key_lo;
                    n_s[3] = i_nonce_high;
                    n_s[4] = i_nonce_low;
                end
                REQ_FIN: begin
                    n_s[1] = r_s[1] ^ r_key_hi;
                    n_s[2] = r_s[2] ^ r_key_lo;
                end
                default: n_s = r_s;
            endcase
        end else if (i_cmd.round) begin
            n_s = round_out;
        end else if (i_cmd.finish) begin
            unique case (r_req)
                REQ_START: begin
                    n_s[3]    = r_s[3] ^ r_key_hi;
                    n_s[4]    = r_s[4] ^ r_key_lo;
                    n_pending = 1'b1;
                end
                REQ_ENC, REQ_DEC: begin
                    n_out_word = r_data ^ r_s[0];
                    n_s[0]     = (r_req == REQ_ENC) ? n_out_word : r_data;
                    n_pending  = 1'b0;
                end
                REQ_FIN: begin
                    n_s[3]      = r_s[3] ^ r_key_hi;
                    n_s[4]      = r_s[4] ^ r_key_lo;
                    n_tag_hi    = n_s[3];
                    n_tag_lo    = n_s[4];
                    n_tag_match = (n_s[3] == r_exp_hi) && (n_s[4] == r_exp_lo);
                end
                default: n_s = r_s;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s         <= '0;
            r_pending   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_s       <= n_s;
            r_pending <= n_pending;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_word  <= n_out_word;
            r_tag_hi    <= n_tag_hi;
            r_tag_lo    <= n_tag_lo;
            r_tag_match <= n_tag_match;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_tag_high  = r_tag_hi;
    assign o_tag_low   = r_tag_lo;
    assign o_tag_match = r_tag_match;

endmodule
`default_nettype wire

// ----- rtl/ascon_aead_block_core_unit.sv -----
// Top level: Ascon-128 style sponge engine, one request word in, one result word out
//
//   channel | direction | handshake                 | payload
//   cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//   in      | in        | i_in_valid / o_in_ready   | i_req_type, i_data_word, nonce, tag
//   out     | out       | o_out_valid / i_out_ready | o_out_word, o_tag_*, o_tag_match
//
// One permutation round per cycle. Each request has an accept and a finish step;
// start and finalize run rounds RND_FIRST_FULL to RND_LAST between them, a data
// word only RND_FIRST_HALF to RND_LAST, the first data word after start none.
// Reset (i_rst_n low, synchronous) clears the sponge and the key and sets the
// first-block flag.
// A finished word waits in the output register; the core holds in its finish step
// only while that register is full and not being taken.
`default_nettype none
module ascon_aead_block_core_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire ascon_pkg::t_word     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_req_type,
    input  wire ascon_pkg::t_word     i_data_word,
    input  wire ascon_pkg::t_word     i_nonce_high,
    input  wire ascon_pkg::t_word     i_nonce_low,
    input  wire ascon_pkg::t_word     i_expected_tag_high,
    input  wire ascon_pkg::t_word     i_expected_tag_low,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ascon_pkg::t_word          o_out_word,
    output ascon_pkg::t_word          o_tag_high,
    output ascon_pkg::t_word          o_tag_low,
    output logic                      o_tag_match
);
    import ascon_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    ascon_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ascon_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_req_type          (i_req_type),
        .i_data_word         (i_data_word),
        .i_nonce_high        (i_nonce_high),
        .i_nonce_low         (i_nonce_low),
        .i_expected_tag_high (i_expected_tag_high),
        .i_expected_tag_low  (i_expected_tag_low),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_word          (o_out_word),
        .o_tag_high          (o_tag_high),
        .o_tag_low           (o_tag_low),
        .o_tag_match         (o_tag_match)
    );

endmodule
`default_nettype wire
